FILE: hw/rtl/bms_pkg.sv
`default_nettype none

package bms_pkg;

   typedef enum logic [2:0] {
      MODE_INITIAL = 3'd0,
      MODE_STANDBY = 3'd1,
      MODE_CONFIRM = 3'd2,
      MODE_WORKING = 3'd3,
      MODE_HOLD    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      EVENT_NONE     = 2'd0,
      EVENT_RELEASED = 2'd1,
      EVENT_PRESSED  = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_INITIAL = 2'd1,
      CMD_STANDBY = 2'd2,
      CMD_CONFIRM = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_DEBOUNCE    = 3'd0,
      REG_CONFIRM     = 3'd1,
      REG_HOLD        = 3'd2,
      REG_SLOW_PERIOD = 3'd3,
      REG_SLOW_ON     = 3'd4,
      REG_FAST_PERIOD = 3'd5,
      REG_FAST_ON     = 3'd6,
      REG_SPARE       = 3'd7
   } reg_index_type;

   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [7:0]  DEBOUNCE_RESET    = 8'd50;
   localparam logic [15:0] CONFIRM_RESET     = 16'd1000;
   localparam logic [15:0] HOLD_RESET        = 16'd3000;
   localparam logic [15:0] SLOW_PERIOD_RESET = 16'd3000;
   localparam logic [15:0] SLOW_ON_RESET     = 16'd2400;
   localparam logic [15:0] FAST_PERIOD_RESET = 16'd200;
   localparam logic [15:0] FAST_ON_RESET     = 16'd100;

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/button_mode_sequencer_unit.sv
`default_nettype none

// Button mode sequencer: each request is one millisecond tick carrying the raw active-low
// button level (tdata bit 0) and a command (bits 2:1). Every request yields exactly one
// response with the LED drive, the mode after the tick and any press/release event. One
// request is accepted per clock; its response is registered in the single output register
// and holds there while rsp_tready is low, and req_tready stays high as long as that
// register is empty or being emptied in the same cycle. The debounce, sequencer and blink
// counters all update in the accepting cycle. The user must write registers over the APB
// port only while no request is in flight; the block itself does not enforce this.
module button_mode_sequencer_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [7:0]                         req_tdata,  // button_level, cmd, zero fill
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [7:0]                         rsp_tdata,  // led_on, mode_state,
                                                               // button_event, zero fill
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [bms_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output      logic [31:0]                        prdata,
   output      logic                               pready
);

   logic [7:0]  debounce_ff;
   logic [15:0] confirm_ff;
   logic [15:0] hold_ff;
   logic [15:0] slow_period_ff;
   logic [15:0] slow_on_ff;
   logic [15:0] fast_period_ff;
   logic [15:0] fast_on_ff;

   bms_pkg::mode_type mode_ff, mode_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  timer_ff, timer_in;
   logic        prior_ff, prior_in;
   logic        stable_ff, stable_in;
   logic        reported_ff, reported_in;
   logic [15:0] slow_phase_ff, slow_phase_in;
   logic [15:0] fast_phase_ff, fast_phase_in;

   logic                rsp_valid_ff;
   logic                led_ff, led_in;
   bms_pkg::mode_type   mode_out_ff;
   bms_pkg::event_type  event_ff, event_in;

   logic                  accept;
   logic                  level;
   bms_pkg::cmd_type      cmd;
   bms_pkg::reg_index_type reg_index;
   logic [7:0]            timer_next;
   logic [15:0]           elapsed_inc;
   logic [16:0]           slow_next;
   logic [16:0]           fast_next;

   assign pready     = 1'b1;
   assign reg_index  = bms_pkg::reg_index_type'(paddr[4:2]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];
   assign cmd        = bms_pkg::cmd_type'(req_tdata[2:1]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, event_ff, mode_out_ff, led_ff};

   always_comb begin
      unique case (reg_index)
         bms_pkg::REG_DEBOUNCE:    prdata = {24'd0, debounce_ff};
         bms_pkg::REG_CONFIRM:     prdata = {16'd0, confirm_ff};
         bms_pkg::REG_HOLD:        prdata = {16'd0, hold_ff};
         bms_pkg::REG_SLOW_PERIOD: prdata = {16'd0, slow_period_ff};
         bms_pkg::REG_SLOW_ON:     prdata = {16'd0, slow_on_ff};
         bms_pkg::REG_FAST_PERIOD: prdata = {16'd0, fast_period_ff};
         bms_pkg::REG_FAST_ON:     prdata = {16'd0, fast_on_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= bms_pkg::DEBOUNCE_RESET;
         confirm_ff     <= bms_pkg::CONFIRM_RESET;
         hold_ff        <= bms_pkg::HOLD_RESET;
         slow_period_ff <= bms_pkg::SLOW_PERIOD_RESET;
         slow_on_ff     <= bms_pkg::SLOW_ON_RESET;
         fast_period_ff <= bms_pkg::FAST_PERIOD_RESET;
         fast_on_ff     <= bms_pkg::FAST_ON_RESET;
      end else if (psel && penable && pwrite && pready) begin
         unique case (reg_index)
            bms_pkg::REG_DEBOUNCE:    debounce_ff    <= pwdata[7:0];
            bms_pkg::REG_CONFIRM:     confirm_ff     <= pwdata[15:0];
            bms_pkg::REG_HOLD:        hold_ff        <= pwdata[15:0];
            bms_pkg::REG_SLOW_PERIOD: slow_period_ff <= pwdata[15:0];
            bms_pkg::REG_SLOW_ON:     slow_on_ff     <= pwdata[15:0];
            bms_pkg::REG_FAST_PERIOD: fast_period_ff <= pwdata[15:0];
            bms_pkg::REG_FAST_ON:     fast_on_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      timer_next  = timer_ff + 8'd1;
      timer_in    = timer_next;
      prior_in    = prior_ff;
      stable_in   = stable_ff;
      reported_in = reported_ff;
      event_in    = bms_pkg::EVENT_NONE;

      // sample the pin once per debounce period
      if (timer_next >= debounce_ff) begin
         timer_in = 8'd0;
         if (level == prior_ff) begin
            stable_in = level;
         end
         prior_in = level;
      end

      if (stable_in != reported_ff) begin
         event_in    = stable_in ? bms_pkg::EVENT_RELEASED : bms_pkg::EVENT_PRESSED;
         reported_in = stable_in;
      end

      elapsed_inc = (elapsed_ff == bms_pkg::ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
      elapsed_in  = elapsed_inc;
      mode_in     = mode_ff;

      unique case (mode_ff)
         bms_pkg::MODE_INITIAL: begin
            mode_in    = bms_pkg::MODE_STANDBY;
            elapsed_in = 16'd0;
         end
         bms_pkg::MODE_STANDBY: begin
            if (event_in == bms_pkg::EVENT_PRESSED) begin
               mode_in    = bms_pkg::MODE_CONFIRM;
               elapsed_in = 16'd0;
            end
         end
         bms_pkg::MODE_CONFIRM: begin
            if (elapsed_inc > confirm_ff) begin
               mode_in    = bms_pkg::MODE_WORKING;
               elapsed_in = 16'd0;
            end
         end
         bms_pkg::MODE_WORKING: begin
            if (event_in == bms_pkg::EVENT_PRESSED) begin
               mode_in    = bms_pkg::MODE_HOLD;
               elapsed_in = 16'd0;
            end
         end
         bms_pkg::MODE_HOLD: begin
            if (event_in == bms_pkg::EVENT_RELEASED) begin
               mode_in    = bms_pkg::MODE_WORKING;
               elapsed_in = 16'd0;
            end else if (elapsed_inc > hold_ff) begin
               mode_in    = bms_pkg::MODE_STANDBY;
               elapsed_in = 16'd0;
            end
         end
         default: begin
            mode_in    = bms_pkg::MODE_INITIAL;
            elapsed_in = 16'd0;
         end
      endcase

      // command overrides the sequencer
      unique case (cmd)
         bms_pkg::CMD_INITIAL: begin
            mode_in    = bms_pkg::MODE_INITIAL;
            elapsed_in = 16'd0;
         end
         bms_pkg::CMD_STANDBY: begin
            mode_in    = bms_pkg::MODE_STANDBY;
            elapsed_in = 16'd0;
         end
         bms_pkg::CMD_CONFIRM: begin
            mode_in    = bms_pkg::MODE_CONFIRM;
            elapsed_in = 16'd0;
         end
         default: ;
      endcase

      slow_next     = {1'b0, slow_phase_ff} + 17'd1;
      fast_next     = {1'b0, fast_phase_ff} + 17'd1;
      slow_phase_in = (slow_next >= {1'b0, slow_period_ff}) ? 16'd0 : slow_next[15:0];
      fast_phase_in = (fast_next >= {1'b0, fast_period_ff}) ? 16'd0 : fast_next[15:0];

      unique case (mode_in)
         bms_pkg::MODE_STANDBY: led_in = slow_phase_in > slow_on_ff;
         bms_pkg::MODE_CONFIRM,
         bms_pkg::MODE_HOLD:    led_in = fast_phase_in > fast_on_ff;
         bms_pkg::MODE_WORKING: led_in = 1'b1;
         default:               led_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bms_pkg::MODE_INITIAL;
         elapsed_ff    <= 16'd0;
         timer_ff      <= 8'd0;
         prior_ff      <= 1'b1;
         stable_ff     <= 1'b1;
         reported_ff   <= 1'b1;
         slow_phase_ff <= 16'd0;
         fast_phase_ff <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            elapsed_ff    <= elapsed_in;
            timer_ff      <= timer_in;
            prior_ff      <= prior_in;
            stable_ff     <= stable_in;
            reported_ff   <= reported_in;
            slow_phase_ff <= slow_phase_in;
            fast_phase_ff <= fast_phase_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         led_ff      <= led_in;
         mode_out_ff <= mode_in;
         event_ff    <= event_in;
      end
   end

endmodule

`default_nettype wire
